FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the bus node.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that a property holds on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bus node assertion failed");
// Checks that a condition never holds on a rising edge of clk outside reset.
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bus node forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

FILE: hdl/lsbn_pkg.sv
// Types and constants of the LIN-style bus node.
package lsbn_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int LEN_W        = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

  localparam logic [7:0] SYNC_BYTE    = 8'h55;
  localparam logic [7:0] BUS_REQ_BYTE = 8'hFF;

  localparam logic [15:0] REQUEST_INTERVAL_RST = 16'd1000;
  localparam logic [15:0] RECEIVE_TIMEOUT_RST  = 16'd20;

  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_TIMEOUT  = CFG_IDX_W'(1);

  localparam logic [2:0] MODE_RX_BYTE   = 3'd0;
  localparam logic [2:0] MODE_BREAK     = 3'd1;
  localparam logic [2:0] MODE_TIMEOUT   = 3'd2;
  localparam logic [2:0] MODE_LOAD      = 3'd3;
  localparam logic [2:0] MODE_SEND      = 3'd4;
  localparam logic [2:0] MODE_RECEIVE   = 3'd5;
  localparam logic [2:0] MODE_ACK       = 3'd6;

  localparam logic [1:0] TIMER_LEAVE = 2'd0;
  localparam logic [1:0] TIMER_STOP  = 2'd1;
  localparam logic [1:0] TIMER_START = 2'd2;

  localparam logic DONE_SEND    = 1'b0;
  localparam logic DONE_RECEIVE = 1'b1;

  typedef enum logic [1:0] {
    BUS_IDLE     = 2'd0,
    BUS_SYNC     = 2'd1,
    BUS_TRANSFER = 2'd2,
    BUS_ERROR    = 2'd3
  } bus_phase_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PENDING  = 3'd1,
    PH_ACTIVE   = 3'd2,
    PH_END      = 3'd3,
    PH_FINISHED = 3'd4
  } op_phase_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [7:0]       byte_value;
    logic             line_high;
    logic [5:0]       buffer_index;
    logic [LEN_W-1:0] op_length;
  } in_word_t;

  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic [1:0]       timer_action;
    logic [15:0]      timer_period;
    logic             rx_valid;
    logic [5:0]       rx_index;
    logic [7:0]       rx_byte;
    logic             done_valid;
    logic             done_kind;
    logic [LEN_W-1:0] rx_count;
    logic             accepted;
  } out_word_t;

endpackage

FILE: hdl/lin_style_bus_node.sv
// LIN-style bus node: event decoder, transmit buffer memory and result register.
// A word accepted into the execute stage register gives its result word on out_* from the output register.
// Throughput: one word per cycle while out_stall is low; the memory read for a word is issued as it is accepted.
// A stalled output holds the execute stage, which then stalls the input channel.
// Reset (rst_n low, synchronous) idles all phases and restores the register defaults;
// the transmit buffer is not cleared and holds undefined bytes until loaded.
`include "assert_macros.svh"

module lin_style_bus_node
  import lsbn_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // The design has two stages. The accept stage registers the word and reads
  // the transmit buffer at the position that the word may need. The execute
  // stage then decodes the word against the phase registers and the read
  // byte, writes the buffer for a load and places the result in the output
  // register.

  logic [15:0] request_interval_r;
  logic [15:0] receive_timeout_r;

  bus_phase_t       bus_phase_r, bus_phase_nxt;
  op_phase_t        send_phase_r, send_phase_nxt;
  op_phase_t        recv_phase_r, recv_phase_nxt;
  logic [LEN_W-1:0] tx_position_r, tx_position_nxt;
  logic [LEN_W-1:0] tx_count_r, tx_count_nxt;
  logic [7:0]       last_sent_r, last_sent_nxt;
  logic [LEN_W-1:0] rx_position_r, rx_position_nxt;
  logic [LEN_W-1:0] rx_limit_r, rx_limit_nxt;
  logic [15:0]      timer_compare_r, timer_compare_nxt;

  // Execute stage holding register.
  logic     s1_valid_r, s1_valid_nxt;
  in_word_t s1_word_r;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, res;

  // Transmit buffer and its read path.
  logic [7:0]        tx_mem [BUFFER_DEPTH];
  logic [7:0]        mem_q_r;
  logic              fwd_hit_r;
  logic [7:0]        fwd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              fwd_hit_nxt;
  logic [7:0]        buf_byte;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;

  logic in_acc;
  logic s1_fire;
  logic send_wants;

  // Configuration writes are always taken; the user must send them only while the node is idle, which is not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_interval_r <= REQUEST_INTERVAL_RST;
      receive_timeout_r  <= RECEIVE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REQUEST_INTERVAL: request_interval_r <= cfg_data;
        REG_RECEIVE_TIMEOUT:  receive_timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake. The execute stage retires its word whenever the output
  // register is free or is being emptied in the same cycle.
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // The byte that the execute stage sees: the registered memory read, or the
  // byte that a load wrote to the same entry in the cycle of the read.
  assign buf_byte   = fwd_hit_r ? fwd_data_r : mem_q_r;
  assign send_wants = (send_phase_r == PH_PENDING) || (send_phase_r == PH_ACTIVE) ||
                      (send_phase_r == PH_END);

  // Execute stage: next state and result word.
  always_comb begin
    bus_phase_nxt     = bus_phase_r;
    send_phase_nxt    = send_phase_r;
    recv_phase_nxt    = recv_phase_r;
    tx_position_nxt   = tx_position_r;
    tx_count_nxt      = tx_count_r;
    last_sent_nxt     = last_sent_r;
    rx_position_nxt   = rx_position_r;
    rx_limit_nxt      = rx_limit_r;
    timer_compare_nxt = timer_compare_r;
    res               = '0;
    mem_we            = 1'b0;
    wr_addr           = s1_word_r.buffer_index[ADDR_W-1:0];

    if (s1_fire) begin
      unique case (s1_word_r.mode)
        MODE_RX_BYTE: begin
          res.timer_action = TIMER_STOP;
          unique case (bus_phase_r)
            BUS_IDLE: begin
              if (send_wants) begin
                res.timer_action = TIMER_START;
                res.timer_period = timer_compare_r;
              end
            end
            BUS_SYNC: begin
              if (s1_word_r.byte_value != SYNC_BYTE) begin
                bus_phase_nxt = BUS_ERROR;
              end else begin
                if (recv_phase_r == PH_PENDING || recv_phase_r == PH_ACTIVE) begin
                  recv_phase_nxt  = PH_ACTIVE;
                  rx_position_nxt = '0;
                end
                if (send_wants) begin
                  // The buffer was read at the first entry for this word.
                  send_phase_nxt  = PH_ACTIVE;
                  last_sent_nxt   = buf_byte;
                  tx_position_nxt = LEN_W'(1);
                  res.tx_valid    = 1'b1;
                  res.tx_byte     = buf_byte;
                end
                bus_phase_nxt = BUS_TRANSFER;
              end
              res.timer_action = TIMER_START;
              res.timer_period = timer_compare_r;
            end
            BUS_TRANSFER: begin
              if (send_phase_r == PH_ACTIVE) begin
                // Our own echo must come back unchanged with the line high,
                // otherwise another node has won the bus.
                if (s1_word_r.byte_value == last_sent_r && s1_word_r.line_high) begin
                  if (tx_position_r < tx_count_r) begin
                    last_sent_nxt   = buf_byte;
                    tx_position_nxt = tx_position_r + LEN_W'(1);
                    res.tx_valid    = 1'b1;
                    res.tx_byte     = buf_byte;
                  end else begin
                    send_phase_nxt = PH_END;
                  end
                end else begin
                  send_phase_nxt = PH_PENDING;
                end
              end else if (send_phase_r == PH_END) begin
                send_phase_nxt = PH_PENDING;
              end
              if (recv_phase_r == PH_ACTIVE && rx_position_r < rx_limit_r) begin
                res.rx_valid    = 1'b1;
                res.rx_index    = rx_position_r[5:0];
                res.rx_byte     = s1_word_r.byte_value;
                rx_position_nxt = rx_position_r + LEN_W'(1);
              end
              res.timer_action = TIMER_START;
              res.timer_period = timer_compare_r;
            end
            default: begin
              res.timer_action = TIMER_START;
              res.timer_period = timer_compare_r;
            end
          endcase
        end
        MODE_BREAK: begin
          timer_compare_nxt = receive_timeout_r;
          res.timer_action  = TIMER_START;
          res.timer_period  = receive_timeout_r;
          bus_phase_nxt     = BUS_SYNC;
        end
        MODE_TIMEOUT: begin
          res.timer_action = TIMER_STOP;
          bus_phase_nxt    = BUS_IDLE;
          if (bus_phase_r == BUS_TRANSFER) begin
            // A completed send is reported ahead of an active receive.
            if (send_phase_r == PH_END) begin
              send_phase_nxt = PH_FINISHED;
              res.done_valid = 1'b1;
              res.done_kind  = DONE_SEND;
            end else if (recv_phase_r == PH_ACTIVE) begin
              recv_phase_nxt = PH_FINISHED;
              res.done_valid = 1'b1;
              res.done_kind  = DONE_RECEIVE;
              res.rx_count   = rx_position_r;
            end
          end else if (send_wants) begin
            res.tx_valid      = 1'b1;
            res.tx_byte       = BUS_REQ_BYTE;
            timer_compare_nxt = request_interval_r;
            res.timer_action  = TIMER_START;
            res.timer_period  = request_interval_r;
          end
        end
        MODE_LOAD: begin
          mem_we = (LEN_W'(s1_word_r.buffer_index) < DEPTH_LEN);
        end
        MODE_SEND: begin
          if (send_phase_r == PH_IDLE && s1_word_r.op_length != '0) begin
            res.accepted    = 1'b1;
            send_phase_nxt  = PH_PENDING;
            tx_position_nxt = '0;
            tx_count_nxt    = (s1_word_r.op_length > DEPTH_LEN) ? DEPTH_LEN :
                                                                  s1_word_r.op_length;
            if (bus_phase_r == BUS_IDLE) begin
              res.tx_valid      = 1'b1;
              res.tx_byte       = BUS_REQ_BYTE;
              timer_compare_nxt = request_interval_r;
              res.timer_action  = TIMER_START;
              res.timer_period  = request_interval_r;
            end
          end
        end
        MODE_RECEIVE: begin
          if (recv_phase_r == PH_IDLE && s1_word_r.op_length != '0) begin
            res.accepted    = 1'b1;
            recv_phase_nxt  = PH_PENDING;
            rx_position_nxt = '0;
            rx_limit_nxt    = (s1_word_r.op_length > DEPTH_LEN) ? DEPTH_LEN :
                                                                  s1_word_r.op_length;
          end
        end
        MODE_ACK: begin
          if (send_phase_r == PH_FINISHED) begin
            send_phase_nxt = PH_IDLE;
          end else if (recv_phase_r == PH_FINISHED) begin
            recv_phase_nxt = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Read address for the word being accepted, taken from the state that the
  // word will meet in the execute stage: the first entry after a break,
  // otherwise the current send position.
  always_comb begin
    rd_addr     = (bus_phase_nxt == BUS_SYNC) ? '0 : tx_position_nxt[ADDR_W-1:0];
    fwd_hit_nxt = mem_we && (wr_addr == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tx_mem[wr_addr] <= s1_word_r.byte_value;
    end
    if (in_acc) begin
      mem_q_r    <= tx_mem[rd_addr];
      fwd_hit_r  <= fwd_hit_nxt;
      fwd_data_r <= s1_word_r.byte_value;
      s1_word_r  <= in_word;
    end
    if (s1_fire) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_phase_r     <= BUS_IDLE;
      send_phase_r    <= PH_IDLE;
      recv_phase_r    <= PH_IDLE;
      tx_position_r   <= '0;
      tx_count_r      <= '0;
      last_sent_r     <= '0;
      rx_position_r   <= '0;
      rx_limit_r      <= '0;
      timer_compare_r <= REQUEST_INTERVAL_RST;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      bus_phase_r     <= bus_phase_nxt;
      send_phase_r    <= send_phase_nxt;
      recv_phase_r    <= recv_phase_nxt;
      tx_position_r   <= tx_position_nxt;
      tx_count_r      <= tx_count_nxt;
      last_sent_r     <= last_sent_nxt;
      rx_position_r   <= rx_position_nxt;
      rx_limit_r      <= rx_limit_nxt;
      timer_compare_r <= timer_compare_nxt;
      s1_valid_r      <= s1_valid_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // The input is held back only while a word waits in the execute stage.
  `ASSERT_CLK(a_stall_has_word, in_stall |-> s1_valid_r)
  // A completion never goes out together with a byte for the transmitter.
  `ASSERT_NEVER(a_done_without_tx, out_valid_r && out_word_r.done_valid && out_word_r.tx_valid)
  // An active send never runs past the number of bytes it was given.
  `ASSERT_CLK(a_send_in_range, (send_phase_r == PH_ACTIVE) |-> (tx_position_r <= tx_count_r))
  // A word retired while the output is stalled would overwrite a pending result.
  `ASSERT_CLK(a_no_overwrite, (out_valid_r && out_stall) |-> !s1_fire)

endmodule

FILE: sim/lin_style_bus_node_tb.sv
// Self-checking testbench for the LIN-style bus node: directed and random words, predicted results.
`timescale 1ns / 1ps

module lin_style_bus_node_tb;
  import lsbn_pkg::*;

  // The one mode code that the package leaves unnamed; the node must ignore it.
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // A word waiting to be driven, and whether the driver must first see every result back.
  typedef struct {
    in_word_t word;
    bit       hold;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  lin_style_bus_node uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Words still to be driven, and the result words predicted for the words already taken.
  stim_t     pending_words[$];
  out_word_t expected_words[$];

  int errors = 0;
  int words_taken = 0;
  int gen_count = 0;
  int settings_used = 1;
  int sends_done = 0;
  int recvs_done = 0;
  int bytes_stored = 0;
  bit hold_next = 1'b0;

  // The generator keeps its own view of the transmit buffer, so that it can echo the
  // bytes the node is about to send and so that no send ever reads an unloaded entry.
  logic [7:0]              gen_mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] gen_loaded = '0;

  // ---------------------------------------------------------------------------------------
  // Predictor state. It mirrors the node's phases, buffer, counters and the two registers.
  // ---------------------------------------------------------------------------------------
  bus_phase_t  nd_bus;
  op_phase_t   nd_send;
  op_phase_t   nd_recv;
  logic [7:0]  nd_mem [BUFFER_DEPTH];
  logic [6:0]  nd_tx_pos;
  logic [6:0]  nd_tx_len;
  logic [7:0]  nd_last_tx;
  logic [6:0]  nd_rx_pos;
  logic [6:0]  nd_rx_max;
  logic [15:0] nd_cmp;
  logic [15:0] nd_req_iv;
  logic [15:0] nd_rx_to;

  function automatic void node_clear();
    nd_bus     = BUS_IDLE;
    nd_send    = PH_IDLE;
    nd_recv    = PH_IDLE;
    nd_tx_pos  = '0;
    nd_tx_len  = '0;
    nd_last_tx = '0;
    nd_rx_pos  = '0;
    nd_rx_max  = '0;
    nd_req_iv  = REQUEST_INTERVAL_RST;
    nd_rx_to   = RECEIVE_TIMEOUT_RST;
    nd_cmp     = REQUEST_INTERVAL_RST;
    for (int i = 0; i < BUFFER_DEPTH; i++) nd_mem[i] = '0;
  endfunction

  // A send holds a claim on the bus from the moment it is taken until its timeout closes it.
  function automatic bit send_claims_bus();
    return nd_send == PH_PENDING || nd_send == PH_ACTIVE || nd_send == PH_END;
  endfunction

  function automatic void arm_timer(inout out_word_t r);
    r.timer_action = TIMER_START;
    r.timer_period = nd_cmp;
  endfunction

  function automatic void put_tx(inout out_word_t r, input logic [7:0] b);
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
  endfunction

  // The request byte restarts the timer with the repeat interval.
  function automatic void put_request(inout out_word_t r);
    put_tx(r, BUS_REQ_BYTE);
    nd_cmp = nd_req_iv;
    arm_timer(r);
  endfunction

  function automatic logic [6:0] clip_len(input logic [6:0] len);
    return (len > DEPTH_LEN) ? DEPTH_LEN : len;
  endfunction

  // Works out the result word for one input word and advances the predicted state.
  function automatic out_word_t node_respond(input in_word_t w);
    out_word_t r;
    r = '0;
    case (w.mode)
      MODE_RX_BYTE: begin
        r.timer_action = TIMER_STOP;
        case (nd_bus)
          BUS_IDLE: begin
            if (send_claims_bus()) arm_timer(r);
          end
          BUS_SYNC: begin
            if (w.byte_value != SYNC_BYTE) begin
              nd_bus = BUS_ERROR;
            end else begin
              if (nd_recv == PH_PENDING || nd_recv == PH_ACTIVE) begin
                nd_recv   = PH_ACTIVE;
                nd_rx_pos = '0;
              end
              // Every good sync restarts a claiming send from its first byte.
              if (send_claims_bus()) begin
                nd_send    = PH_ACTIVE;
                nd_last_tx = nd_mem[0];
                nd_tx_pos  = 7'd1;
                put_tx(r, nd_last_tx);
              end
              nd_bus = BUS_TRANSFER;
            end
            arm_timer(r);
          end
          BUS_TRANSFER: begin
            if (nd_send == PH_ACTIVE) begin
              // The echo must match what was sent, with the line high, or arbitration is lost.
              if (w.byte_value == nd_last_tx && w.line_high) begin
                if (nd_tx_pos < nd_tx_len) begin
                  nd_last_tx = nd_mem[nd_tx_pos[5:0]];
                  nd_tx_pos  = nd_tx_pos + 7'd1;
                  put_tx(r, nd_last_tx);
                end else begin
                  nd_send = PH_END;
                end
              end else begin
                nd_send = PH_PENDING;
              end
            end else if (nd_send == PH_END) begin
              nd_send = PH_PENDING;
            end
            if (nd_recv == PH_ACTIVE && nd_rx_pos < nd_rx_max) begin
              r.rx_valid = 1'b1;
              r.rx_index = nd_rx_pos[5:0];
              r.rx_byte  = w.byte_value;
              nd_rx_pos  = nd_rx_pos + 7'd1;
            end
            arm_timer(r);
          end
          default: begin
            arm_timer(r);
          end
        endcase
      end
      MODE_BREAK: begin
        nd_cmp = nd_rx_to;
        arm_timer(r);
        nd_bus = BUS_SYNC;
      end
      MODE_TIMEOUT: begin
        r.timer_action = TIMER_STOP;
        if (nd_bus == BUS_TRANSFER) begin
          // A completed send is reported ahead of an active receive.
          if (nd_send == PH_END) begin
            nd_send      = PH_FINISHED;
            r.done_valid = 1'b1;
            r.done_kind  = DONE_SEND;
          end else if (nd_recv == PH_ACTIVE) begin
            nd_recv      = PH_FINISHED;
            r.done_valid = 1'b1;
            r.done_kind  = DONE_RECEIVE;
            r.rx_count   = nd_rx_pos;
          end
          nd_bus = BUS_IDLE;
        end else begin
          nd_bus = BUS_IDLE;
          if (send_claims_bus()) put_request(r);
        end
      end
      MODE_LOAD: begin
        nd_mem[w.buffer_index] = w.byte_value;
      end
      MODE_SEND: begin
        if (nd_send == PH_IDLE && w.op_length != '0) begin
          r.accepted = 1'b1;
          nd_send    = PH_PENDING;
          nd_tx_pos  = '0;
          nd_tx_len  = clip_len(w.op_length);
          if (nd_bus == BUS_IDLE) put_request(r);
        end
      end
      MODE_RECEIVE: begin
        if (nd_recv == PH_IDLE && w.op_length != '0) begin
          r.accepted = 1'b1;
          nd_recv    = PH_PENDING;
          nd_rx_pos  = '0;
          nd_rx_max  = clip_len(w.op_length);
        end
      end
      MODE_ACK: begin
        if (nd_send == PH_FINISHED) nd_send = PH_IDLE;
        else if (nd_recv == PH_FINISHED) nd_recv = PH_IDLE;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Idle and stall lengths. Most are short, a few are long, and at regular stretches there
  // are none at all so that back-to-back words and results are exercised too.
  // ---------------------------------------------------------------------------------------
  function automatic int burst_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if ((words_taken / 96) % 5 == 4) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return burst_len();
  endfunction

  // Transfer lengths are mostly short; now and then a longer one up to a full buffer, or a length that saturates.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 8);
    else if (r < 95) return $urandom_range(9, 64);
    return $urandom_range(65, 127);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver. Taking a word is seen at the rising edge, where the word is handed to the
  // predictor; the next word, or an idle cycle, is set up at the falling edge.
  // ---------------------------------------------------------------------------------------
  bit word_taken = 1'b0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_words.push_back(node_respond(in_word));
      words_taken++;
      word_taken = 1'b1;
    end else begin
      word_taken = 1'b0;
    end
  end

  always @(negedge clk) begin : drive_words
    stim_t nxt;
    if (in_valid && !word_taken) begin
      // The word is stalled and stays on the port unchanged.
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_words.size() != 0 &&
                 !(pending_words[0].hold && expected_words.size() != 0)) begin
      nxt = pending_words.pop_front();
      in_word  <= nxt.word;
      in_valid <= 1'b1;
      gap_left = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result side: random stall at the falling edge, checking at the rising edge.
  // ---------------------------------------------------------------------------------------
  int stall_left = 0;
  int neg_cycles = 0;

  always @(negedge clk) begin
    neg_cycles++;
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ((neg_cycles / 700) % 4 != 3 && $urandom_range(0, 3) == 0) begin
      stall_left = burst_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word %h arrived with nothing expected", out_word);
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("tx_valid", want.tx_valid, out_word.tx_valid);
        check_field("tx_byte", want.tx_byte, out_word.tx_byte);
        check_field("timer_action", want.timer_action, out_word.timer_action);
        check_field("timer_period", want.timer_period, out_word.timer_period);
        check_field("rx_valid", want.rx_valid, out_word.rx_valid);
        check_field("rx_index", want.rx_index, out_word.rx_index);
        check_field("rx_byte", want.rx_byte, out_word.rx_byte);
        check_field("done_valid", want.done_valid, out_word.done_valid);
        check_field("done_kind", want.done_kind, out_word.done_kind);
        check_field("rx_count", want.rx_count, out_word.rx_count);
        check_field("accepted", want.accepted, out_word.accepted);
        if (want.done_valid && want.done_kind == DONE_SEND) sends_done++;
        if (want.done_valid && want.done_kind == DONE_RECEIVE) recvs_done++;
        if (want.rx_valid) bytes_stored++;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------------------

  // Queues one word. A send is never allowed to reach past the loaded part of the buffer;
  // where it would, its length is cut down to something the loaded bytes cover.
  task automatic push_item(input logic [2:0] md, input logic [7:0] bv, input logic lh,
                           input logic [5:0] bi, input logic [6:0] ol);
    stim_t s;
    int room;
    logic [6:0] len;
    len = ol;
    if (md == MODE_LOAD) begin
      gen_mem[bi]    = bv;
      gen_loaded[bi] = 1'b1;
    end
    if (md == MODE_SEND) begin
      room = 0;
      while (room < BUFFER_DEPTH && gen_loaded[room]) room++;
      if (clip_len(len) > room) len = 7'($urandom_range(0, room));
    end
    s.word.mode         = md;
    s.word.byte_value   = bv;
    s.word.line_high    = lh;
    s.word.buffer_index = bi;
    s.word.op_length    = len;
    s.hold    = hold_next;
    hold_next = 1'b0;
    pending_words.push_back(s);
    gen_count++;
  endtask

  // A word of the given mode whose other fields are pure noise.
  task automatic push_mode(input logic [2:0] md);
    push_item(md, 8'($urandom), 1'($urandom), 6'($urandom), 7'($urandom));
  endtask

  task automatic push_rx(input logic [7:0] b, input logic lh);
    push_item(MODE_RX_BYTE, b, lh, 6'($urandom), 7'($urandom));
  endtask

  task automatic push_sync();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) begin
      b = 8'($urandom);
      if (b == SYNC_BYTE) b = SYNC_BYTE ^ 8'h80;
    end else begin
      b = SYNC_BYTE;
    end
    push_rx(b, 1'($urandom));
  endtask

  // Loads every buffer entry once, in a shuffled order, so that any length can be sent.
  task automatic fill_buffer();
    int order [BUFFER_DEPTH];
    int j;
    int t;
    for (int i = 0; i < BUFFER_DEPTH; i++) order[i] = i;
    for (int i = BUFFER_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < BUFFER_DEPTH; i++)
      push_item(MODE_LOAD, 8'($urandom), 1'($urandom), 6'(order[i]), 7'($urandom));
  endtask

  // A full send: request, break, sync, the echo of every byte, timeout and acknowledge.
  // Now and then an echo is corrupted or seen with the line low, which loses arbitration.
  task automatic send_sequence();
    int len;
    int echo;
    logic [7:0] b;
    logic lh;
    int r;
    repeat ($urandom_range(0, 2)) push_mode(MODE_LOAD);
    len = pick_len();
    push_item(MODE_SEND, 8'($urandom), 1'($urandom), 6'($urandom), 7'(len));
    if ($urandom_range(0, 1) == 0)
      push_item(MODE_RECEIVE, 8'($urandom), 1'($urandom), 6'($urandom), 7'(pick_len()));
    if ($urandom_range(0, 3) == 0) push_mode(MODE_TIMEOUT);
    push_mode(MODE_BREAK);
    push_sync();
    echo = (len > BUFFER_DEPTH) ? BUFFER_DEPTH : len;
    for (int i = 0; i < echo; i++) begin
      b  = gen_mem[i];
      lh = 1'b1;
      r  = $urandom_range(0, 29);
      if (r == 0) b = b ^ 8'($urandom_range(1, 255));
      else if (r == 1) lh = 1'b0;
      push_rx(b, lh);
    end
    repeat ($urandom_range(0, 2)) push_rx(8'($urandom), 1'($urandom));
    push_mode(MODE_TIMEOUT);
    push_mode(MODE_ACK);
    // A second transfer lets a receive that was left active finish as well.
    if ($urandom_range(0, 1) == 0) begin
      push_mode(MODE_BREAK);
      push_sync();
      repeat ($urandom_range(0, 4)) push_rx(8'($urandom), 1'($urandom));
      push_mode(MODE_TIMEOUT);
      push_mode(MODE_ACK);
    end
  endtask

  // A receive, sometimes with more bytes than it has room for.
  task automatic recv_sequence();
    int len;
    int room;
    len  = pick_len();
    room = (len > BUFFER_DEPTH) ? BUFFER_DEPTH : len;
    push_item(MODE_RECEIVE, 8'($urandom), 1'($urandom), 6'($urandom), 7'(len));
    push_mode(MODE_BREAK);
    push_sync();
    repeat ($urandom_range(0, room + 2)) push_rx(8'($urandom), 1'($urandom));
    push_mode(MODE_TIMEOUT);
    push_mode(MODE_ACK);
    if ($urandom_range(0, 2) == 0) push_mode(MODE_ACK);
  endtask

  task automatic random_phase(input int count);
    int target;
    int r;
    target = gen_count + count;
    while (gen_count < target) begin
      // Occasionally the sender waits until every outstanding result is back.
      if ($urandom_range(0, 39) == 0) hold_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 40) send_sequence();
      else if (r < 65) recv_sequence();
      else repeat ($urandom_range(1, 5)) push_mode(3'($urandom_range(0, 7)));
    end
  endtask

  // Waits until every word has been taken and every result checked.
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_REQUEST_INTERVAL) nd_req_iv = data;
    else nd_rx_to = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Main sequence: reset, a directed pass on the reset settings, then random phases, each
  // on a new pair of register values written while the node is idle.
  // ---------------------------------------------------------------------------------------
  logic [15:0] iv_set [5];
  logic [15:0] to_set [5];

  initial begin
    node_clear();
    for (int i = 0; i < BUFFER_DEPTH; i++) gen_mem[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words. The unused mode and an acknowledge with nothing finished come first.
    push_item(MODE_UNUSED, 8'hFF, 1'b1, 6'd63, 7'd127);
    push_item(MODE_ACK, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_RX_BYTE, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_TIMEOUT, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_LOAD, 8'hA5, 1'b0, 6'd0, 7'd0);
    push_item(MODE_LOAD, 8'h00, 1'b1, 6'd1, 7'd0);
    push_item(MODE_LOAD, 8'hFF, 1'b0, 6'd2, 7'd0);
    push_item(MODE_LOAD, 8'h5A, 1'b1, 6'd63, 7'd127);
    // A zero-length send is refused, a good one is taken, and a second one is refused as busy.
    push_item(MODE_SEND, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_SEND, 8'h00, 1'b0, 6'd0, 7'd3);
    push_item(MODE_SEND, 8'h00, 1'b0, 6'd0, 7'd2);
    push_item(MODE_RECEIVE, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_RECEIVE, 8'h00, 1'b0, 6'd0, 7'd2);
    // An idle timeout with the send still waiting repeats the request byte.
    push_item(MODE_TIMEOUT, 8'h00, 1'b0, 6'd0, 7'd0);
    hold_next = 1'b1;
    push_item(MODE_BREAK, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_RX_BYTE, SYNC_BYTE, 1'b1, 6'd0, 7'd0);
    // Three clean echoes; the receive fills after two bytes and drops the third.
    push_item(MODE_RX_BYTE, 8'hA5, 1'b1, 6'd0, 7'd0);
    push_item(MODE_RX_BYTE, 8'h00, 1'b1, 6'd0, 7'd0);
    push_item(MODE_RX_BYTE, 8'hFF, 1'b1, 6'd0, 7'd0);
    push_item(MODE_TIMEOUT, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_ACK, 8'h00, 1'b0, 6'd0, 7'd0);
    // A bad sync byte puts the bus in error until the next timeout.
    push_item(MODE_BREAK, 8'h00, 1'b0, 6'd0, 7'd0);
    push_item(MODE_RX_BYTE, 8'h12, 1'b0, 6'd0, 7'd0);
    push_item(MODE_RX_BYTE, 8'hFF, 1'b1, 6'd0, 7'd0);
    push_item(MODE_TIMEOUT, 8'h00, 1'b0, 6'd0, 7'd0);
    settle();

    iv_set[0] = 16'd1;              to_set[0] = 16'd65535;
    iv_set[1] = 16'd65535;          to_set[1] = 16'd1;
    iv_set[2] = 16'($urandom_range(1, 65535));
    to_set[2] = 16'($urandom_range(1, 65535));
    iv_set[3] = REQUEST_INTERVAL_RST; to_set[3] = RECEIVE_TIMEOUT_RST;
    iv_set[4] = 16'($urandom_range(1, 65535));
    to_set[4] = 16'($urandom_range(1, 65535));

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_REQUEST_INTERVAL, iv_set[p]);
      write_reg(REG_RECEIVE_TIMEOUT, to_set[p]);
      settings_used++;
      if (p == 0) fill_buffer();
      random_phase(400);
      settle();
    end

    // A last bounded wait, so that a result that never comes is reported as left over.
    for (int k = 0; k < 20000 && expected_words.size() != 0; k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      errors++;
    end

    $display("Covered %0d words over %0d register settings, with %0d sends and %0d receives",
             words_taken, settings_used, sends_done, recvs_done);
    $display("completed and %0d received bytes stored; %0d mismatches.", bytes_stored, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run needs.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
